// ----- sv/gcm_pkg.sv -----
// Shared types and constants for the greedy change maker.
// Depends on nothing; every other file uses it.
package gcm_pkg;

  localparam int AMOUNT_W        = 24;
  localparam int DENOM_W         = 16;
  localparam int COUNT_W         = 24;
  localparam int LEFT_W          = 16;
  localparam int CFG_IDX_W       = 8;
  localparam int DENOM_SLOTS     = 8;
  localparam int SLOT_W          = $clog2(DENOM_SLOTS);
  localparam int SLOT_CNT_W      = $clog2(DENOM_SLOTS + 1);
  localparam int NUM_DENOMS_DEF  = 8;
  localparam int AMOUNT_BITS_DEF = 24;

  localparam logic [DENOM_W-1:0] DENOM_RESET [DENOM_SLOTS] = '{
    16'd200, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd2, 16'd1
  };

  localparam logic [LEFT_W-1:0] LEFT_MAX = '1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ----- sv/gcm_ifs.sv -----
// Valid/ready channel interfaces for the greedy change maker.
// Depends on gcm_pkg for field widths.
interface gcm_in_if;
  logic                         valid;
  logic                         ready;
  logic [gcm_pkg::AMOUNT_W-1:0] amount_cents;
  modport source (output valid, output amount_cents, input ready);
  modport sink (input valid, input amount_cents, output ready);
endinterface

interface gcm_out_if;
  logic                        valid;
  logic                        ready;
  logic [gcm_pkg::DENOM_W-1:0] denomination;
  logic [gcm_pkg::COUNT_W-1:0] unit_count;
  logic [gcm_pkg::LEFT_W-1:0]  leftover;
  logic                        last;
  modport source (output valid, output denomination, output unit_count,
                  output leftover, output last, input ready);
  modport sink (input valid, input denomination, input unit_count,
                input leftover, input last, output ready);
endinterface

interface gcm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gcm_pkg::CFG_IDX_W-1:0] index;
  logic [gcm_pkg::DENOM_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/gcm_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on gcm_pkg for the divisor width and status struct.
module gcm_div #(
  parameter int DIV_W = gcm_pkg::AMOUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DIV_W-1:0]            dividend,
  input  logic [gcm_pkg::DENOM_W-1:0] divisor,
  output gcm_pkg::div_sts_t           sts,
  output logic [DIV_W-1:0]            quotient,
  output logic [gcm_pkg::DENOM_W-1:0] remainder
);
  import gcm_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DENOM_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]   dq_r, dq_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DENOM_W:0]   trial;
  logic [DENOM_W:0]   diff;
  logic               ge;

  always_comb begin
    trial    = {rem_r, dq_r[DIV_W-1]};
    diff     = trial - {1'b0, divisor};
    ge       = (trial >= {1'b0, divisor});
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      dq_nxt   = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DENOM_W-1:0] : trial[DENOM_W-1:0];
      dq_nxt  = {dq_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign sts       = '{busy: busy_r, done: done_r};
  assign quotient  = dq_r;
  assign remainder = rem_r;

endmodule

// ----- sv/greedy_change_maker.sv -----
// Greedy change maker: splits an amount into counts over eight denominations.
// Depends on gcm_pkg, the channel interfaces in gcm_ifs.sv and gcm_div.
//
// Usage:
//   in_chan  takes one word per amount (amount_cents); bits at and above
//            AMOUNT_BITS are dropped.
//   out_chan gives one word per denomination with a nonzero count, in
//            register order; the final word has last set and the unpaid
//            rest in leftover (saturated to 16 bits). When nothing is paid
//            a single word with denomination 0 and count 0 is given.
//   cfg_chan writes denomination register index (0..7); ready is always
//            high; higher indexes are dropped. Write only while idle.
// Timing:
//   Each used nonzero denomination runs through the bit-serial divider,
//   one quotient bit per cycle; a zero denomination is skipped without
//   a division. One amount is in work at a time; the next is taken once
//   the last word sits in the output register.
// Reset: denominations return to 200,100,50,20,10,5,2,1 and the block idles.
// A stalled receiver holds the output word; the walk waits once the next
// word has nowhere to go.
module greedy_change_maker #(
  parameter int NUM_DENOMS  = gcm_pkg::NUM_DENOMS_DEF,
  parameter int AMOUNT_BITS = gcm_pkg::AMOUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gcm_in_if.sink    in_chan,
  gcm_out_if.source out_chan,
  gcm_cfg_if.sink   cfg_chan
);
  import gcm_pkg::*;

  localparam int RW = (AMOUNT_BITS < AMOUNT_W) ? AMOUNT_BITS : AMOUNT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_DIV   = 5'b00100,
    S_POST  = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_CNT_W-1:0] k_r, k_nxt;
  logic [RW-1:0]         rest_r, rest_nxt;
  logic                  pend_r, pend_nxt;
  logic [DENOM_W-1:0]    pend_den_r, pend_den_nxt;
  logic [COUNT_W-1:0]    pend_cnt_r, pend_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DENOM_W-1:0]    out_den_r, out_den_nxt;
  logic [COUNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic [LEFT_W-1:0]     out_left_r, out_left_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [DENOM_W-1:0]    denom_r [DENOM_SLOTS];
  logic [DENOM_W-1:0]    denom_nxt [DENOM_SLOTS];

  logic [DENOM_W-1:0]    d_cur;
  logic                  out_free;
  logic                  div_start;
  logic [31:0]           rest_wide;
  logic [LEFT_W-1:0]     left_sat;
  div_sts_t              div_sts;
  logic [RW-1:0]         div_quo;
  logic [DENOM_W-1:0]    div_rem;

  gcm_div #(.DIV_W(RW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rest_r),
    .divisor   (d_cur),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    d_cur     = denom_r[k_r[SLOT_W-1:0]];
    out_free  = !out_valid_r || out_chan.ready;
    rest_wide = 32'(rest_r);
    left_sat  = (rest_wide > 32'(LEFT_MAX)) ? LEFT_MAX : rest_wide[LEFT_W-1:0];
    div_start = 1'b0;

    state_nxt     = state_r;
    k_nxt         = k_r;
    rest_nxt      = rest_r;
    pend_nxt      = pend_r;
    pend_den_nxt  = pend_den_r;
    pend_cnt_nxt  = pend_cnt_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_den_nxt   = out_den_r;
    out_cnt_nxt   = out_cnt_r;
    out_left_nxt  = out_left_r;
    out_last_nxt  = out_last_r;

    for (int i = 0; i < DENOM_SLOTS; i++) begin
      denom_nxt[i] = denom_r[i];
    end
    if (cfg_chan.valid && (cfg_chan.index < CFG_IDX_W'(DENOM_SLOTS))) begin
      denom_nxt[cfg_chan.index[SLOT_W-1:0]] = cfg_chan.data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          rest_nxt  = in_chan.amount_cents[RW-1:0];
          k_nxt     = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (k_r == SLOT_CNT_W'(NUM_DENOMS)) begin
          state_nxt = S_FINAL;
        end else if (d_cur == '0) begin
          k_nxt = k_r + SLOT_CNT_W'(1);
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        rest_nxt = RW'(div_rem);
        if (div_quo != '0) begin
          if (!pend_r || out_free) begin
            if (pend_r) begin
              out_valid_nxt = 1'b1;
              out_den_nxt   = pend_den_r;
              out_cnt_nxt   = pend_cnt_r;
              out_left_nxt  = '0;
              out_last_nxt  = 1'b0;
            end
            pend_nxt     = 1'b1;
            pend_den_nxt = d_cur;
            pend_cnt_nxt = COUNT_W'(div_quo);
            k_nxt        = k_r + SLOT_CNT_W'(1);
            state_nxt    = S_LOAD;
          end
        end else begin
          k_nxt     = k_r + SLOT_CNT_W'(1);
          state_nxt = S_LOAD;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_den_nxt   = pend_r ? pend_den_r : '0;
          out_cnt_nxt   = pend_r ? pend_cnt_r : '0;
          out_left_nxt  = left_sat;
          out_last_nxt  = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DENOM_SLOTS; i++) begin
        denom_r[i] <= DENOM_RESET[i];
      end
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < DENOM_SLOTS; i++) begin
        denom_r[i] <= denom_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    rest_r     <= rest_nxt;
    pend_den_r <= pend_den_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    out_den_r  <= out_den_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_left_r <= out_left_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign cfg_chan.ready        = 1'b1;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.denomination = out_den_r;
  assign out_chan.unit_count   = out_cnt_r;
  assign out_chan.leftover     = out_left_r;
  assign out_chan.last         = out_last_r;

`ifndef SYNTHESIS
  a_zero_count_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.unit_count == '0))
      |-> (out_chan.last && (out_chan.denomination == '0)))
    else $error("zero count word without last flag");

  a_leftover_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.last) |-> (out_chan.leftover == '0))
    else $error("leftover on a word that is not last");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV))
    else $error("divider finished outside division state");

  a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) && !div_sts.done) |-> div_sts.busy)
    else $error("divider idle while division state waits");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("pending word left behind at idle");
`endif

endmodule
